// File: rtl/bped_pkg.sv
// Package for the button press event detector.
// Holds the item types, the configuration register map and reset values.
// No dependencies.
package bped_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LONG_PRESS_MS      = 1'b0,
        REG_REPEAT_INTERVAL_MS = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_MS_RESET      = 16'd500;
    localparam logic [CFG_DATA_W-1:0] REPEAT_INTERVAL_MS_RESET = 16'd50;

    localparam logic [15:0] REPEATS_MAX = 16'hFFFF;

    typedef struct packed {
        logic        held;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic        press_event;
        logic        long_press_event;
        logic        repeat_event;
        logic        release_event;
        logic        short_release_event;
        logic        long_release_event;
        logic [31:0] hold_ms;
        logic [15:0] repeats;
    } out_item_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] long_press_ms;
        logic [CFG_DATA_W-1:0] repeat_interval_ms;
    } cfg_t;

endpackage

// File: rtl/bped_stage.sv
// One register stage with valid/ready flow control for any packed payload.
// Used for the input register and the result register. No package needed.
module bped_stage #(
    parameter type payload_t = logic
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  payload_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output payload_t out_data
);

    logic     valid_reg;
    payload_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

endmodule

// File: rtl/bped_eval.sv
// Event evaluation: timing state registers and the per-item event logic.
// Depends on bped_pkg.
module bped_eval #(
    parameter int TIME_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  bped_pkg::cfg_t     cfg,
    input  bped_pkg::in_item_t item,
    output bped_pkg::out_item_t result
);
    import bped_pkg::*;

    typedef logic [TIME_BITS-1:0] time_t;

    logic        was_pressed_reg, was_pressed_next;
    time_t       hold_reg, hold_next;
    time_t       prev_reg, prev_next;
    time_t       long_stamp_reg, long_stamp_next;
    time_t       rep_stamp_reg, rep_stamp_next;
    logic [15:0] rep_count_reg, rep_count_next;

    time_t now_t, long_t, intv_t, hold_cur;
    logic  rising, falling, long_ok, fire_long, fire_rep;

    always_comb begin
        now_t  = TIME_BITS'(item.now_ms);
        long_t = TIME_BITS'(cfg.long_press_ms);
        intv_t = TIME_BITS'(cfg.repeat_interval_ms);

        rising  = !was_pressed_reg && item.held;
        falling = was_pressed_reg && !item.held;

        hold_cur = item.held ? time_t'(hold_reg + (now_t - prev_reg)) : hold_reg;
        long_ok  = item.held && (hold_cur >= long_t);
        // now - (hold + now - prev) reduces to prev - hold
        fire_long = !rising && long_ok && (long_stamp_reg <= time_t'(prev_reg - hold_reg));
        fire_rep  = !rising && long_ok && !fire_long
                    && (time_t'(now_t - rep_stamp_reg) >= intv_t);

        was_pressed_next = item.held;
        hold_next        = rising ? '0 : hold_cur;
        prev_next        = now_t;
        long_stamp_next  = long_stamp_reg;
        rep_stamp_next   = rep_stamp_reg;
        rep_count_next   = rep_count_reg;
        if (fire_long) begin
            long_stamp_next = now_t;
            rep_stamp_next  = time_t'(now_t - intv_t);
            rep_count_next  = '0;
        end else if (fire_rep) begin
            rep_stamp_next = now_t;
            if (rep_count_reg != REPEATS_MAX) begin
                rep_count_next = rep_count_reg + 16'd1;
            end
        end

        result.press_event         = rising;
        result.long_press_event    = fire_long;
        result.repeat_event        = fire_rep;
        result.release_event       = falling;
        result.short_release_event = falling && (hold_cur < long_t);
        result.long_release_event  = falling && (hold_cur >= long_t);
        result.hold_ms             = 32'(hold_next);
        result.repeats             = rep_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_pressed_reg <= 1'b0;
            hold_reg        <= '0;
            prev_reg        <= '0;
            long_stamp_reg  <= '0;
            rep_stamp_reg   <= '0;
            rep_count_reg   <= '0;
        end else if (advance) begin
            was_pressed_reg <= was_pressed_next;
            hold_reg        <= hold_next;
            prev_reg        <= prev_next;
            long_stamp_reg  <= long_stamp_next;
            rep_stamp_reg   <= rep_stamp_next;
            rep_count_reg   <= rep_count_next;
        end
    end

endmodule

// File: rtl/button_press_event_detector.sv
// Top level of the button press event detector with long press and auto-repeat.
// Depends on bped_pkg, bped_stage and bped_eval.
//
//   channel   | ports                        | carries
//   ----------+------------------------------+---------------------------------
//   input     | s_valid s_ready s_item       | button level and ms timestamp
//   result    | m_valid m_ready m_item       | event flags, hold time, repeats
//   config    | cfg_we cfg_index cfg_wdata   | long press time, repeat interval
//
// One item per cycle sustained while m_ready stays high.
// Input register -> event logic with timing state -> result register.
// Reset is synchronous on aresetn; config returns to 500 ms / 50 ms.
// A stalled result register holds the item; an empty input register still
// takes one more item, then s_ready drops until m_ready frees the pipe.
module button_press_event_detector #(
    parameter int TIME_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  bped_pkg::in_item_t                   s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bped_pkg::out_item_t                  m_item,
    input  logic                                 cfg_we,
    input  logic [bped_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bped_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import bped_pkg::*;

    cfg_t      cfg_reg;
    in_item_t  in_q;
    out_item_t eval_res;
    logic      in_q_valid, res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms      <= LONG_PRESS_MS_RESET;
            cfg_reg.repeat_interval_ms <= REPEAT_INTERVAL_MS_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_LONG_PRESS_MS:      cfg_reg.long_press_ms      <= cfg_wdata;
                REG_REPEAT_INTERVAL_MS: cfg_reg.repeat_interval_ms <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bped_stage #(.payload_t(in_item_t)) u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_item),
        .out_valid (in_q_valid),
        .out_ready (res_ready),
        .out_data  (in_q)
    );

    bped_eval #(.TIME_BITS(TIME_BITS)) u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (in_q_valid && res_ready),
        .cfg     (cfg_reg),
        .item    (in_q),
        .result  (eval_res)
    );

    bped_stage #(.payload_t(out_item_t)) u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_q_valid),
        .in_ready  (res_ready),
        .in_data   (eval_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_item)
    );

    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_item.press_event, m_item.long_press_event,
                              m_item.repeat_event, m_item.release_event}))
        else $error("more than one primary event in a result");

    a_release_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.release_event ==
                     (m_item.short_release_event ^ m_item.long_release_event)))
        else $error("release kind does not match release event");

    a_press_clears_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.press_event) |-> (m_item.hold_ms == 32'd0))
        else $error("hold time not cleared on press");

    a_long_clears_repeats: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.long_press_event) |-> (m_item.repeats == 16'd0))
        else $error("repeat count not cleared on long press");

endmodule
